// ===== rtl/v3an_pkg.sv =====
`timescale 1ns / 1ps

package v3an_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MODE_BITS = 3;

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = 2 * WORD_BITS + 2;   // sum of squares / dot accumulator
   localparam int ROOT_BITS = WORD_BITS + 1;       // floor sqrt of SUM_BITS value
   localparam int REM_BITS  = ROOT_BITS + 2;       // sqrt partial remainder
   localparam int QUO_BITS  = FRAC_BITS + 1;       // |a| <= len, so quotient <= 1.0

   localparam int REQ_BITS  = ((MODE_BITS + 7 * WORD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = ((4 * WORD_BITS + 1 + 7) / 8) * 8;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_DOT  = 3'd3,
      MODE_SCL  = 3'd4,
      MODE_NORM = 3'd5
   } mode_type;

   // one word as it moves down the cell chain
   typedef struct packed {
      logic                                valid;
      logic                                norm;
      logic                                ovf;
      logic [2:0][WORD_BITS-1:0]           r;
      logic [WORD_BITS-1:0]                dot;
      logic [SUM_BITS-1:0]                 rad;
      logic [REM_BITS-1:0]                 rem;
      logic [ROOT_BITS-1:0]                root;
      logic [2:0][QUO_BITS-1:0]            num;
      logic [2:0][ROOT_BITS-1:0]           drem;
      logic [2:0][QUO_BITS-1:0]            q;
   } item_type;

   // clamp to the signed word range; top bit of result is the clamp flag
   function automatic logic [WORD_BITS:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] maxv;
      logic signed [SUM_BITS-1:0] minv;
      maxv = {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
      minv = ~maxv;
      if (v > maxv) begin
         return {1'b1, maxv[WORD_BITS-1:0]};
      end else if (v < minv) begin
         return {1'b1, minv[WORD_BITS-1:0]};
      end
      return {1'b0, v[WORD_BITS-1:0]};
   endfunction

endpackage

// ===== rtl/v3an_sqrt_cell.sv =====
`timescale 1ns / 1ps

// one digit of the restoring square root: two radicand bits in, one root bit out
module v3an_sqrt_cell
   import v3an_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  item_type d_in,
   output item_type d_out
);

   item_type             q_ff, q_in;
   logic [REM_BITS-1:0]  rem_s, trial;

   always_comb begin
      q_in  = d_in;
      rem_s = {d_in.rem[REM_BITS-3:0], d_in.rad[SUM_BITS-1 -: 2]};
      trial = {d_in.root, 2'b01};
      q_in.rad = d_in.rad << 2;
      if (rem_s >= trial) begin
         q_in.rem  = rem_s - trial;
         q_in.root = {d_in.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         q_in.rem  = rem_s;
         q_in.root = {d_in.root[ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ===== rtl/v3an_div_cell.sv =====
`timescale 1ns / 1ps

// one quotient bit of |component| / length, for all three lanes
module v3an_div_cell
   import v3an_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  item_type d_in,
   output item_type d_out
);

   item_type            q_ff, q_in;
   logic [ROOT_BITS:0]  t [3];
   logic [ROOT_BITS:0]  diff [3];

   always_comb begin
      q_in = d_in;
      for (int i = 0; i < 3; i++) begin
         t[i]    = {d_in.drem[i], d_in.num[i][QUO_BITS-1]};
         diff[i] = t[i] - {1'b0, d_in.root};
         q_in.num[i] = d_in.num[i] << 1;
         if (t[i] >= {1'b0, d_in.root}) begin
            q_in.drem[i] = diff[i][ROOT_BITS-1:0];
            q_in.q[i]    = (d_in.q[i] << 1) | QUO_BITS'(1);
         end else begin
            q_in.drem[i] = t[i][ROOT_BITS-1:0];
            q_in.q[i]    = d_in.q[i] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ===== rtl/vector3_alu_with_normalize.sv =====
`timescale 1ns / 1ps

// Three-component Q16.16 vector unit: add, subtract, component-wise multiply,
// dot product, scale by a factor, or normalize A. One word is accepted every
// cycle while the output side keeps up. An accepted word passes in order through
// the front and sum stages, the chain of square-root cells (one root bit per
// cell), the chain of divider cells (one quotient bit per cell) and the output
// register that drives rsp_tvalid. All modes travel the same chain so words
// leave in order. The whole chain moves together and holds when the output
// word is not taken; req_tready follows that. Saturating modes raise overflow;
// normalize never does, and a zero vector is passed through unchanged. Modes 6
// and 7 answer all zeros.
module vector3_alu_with_normalize
   import v3an_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // mode, ax, ay, az, bx, by, bz, factor
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata    // rx, ry, rz, dot_value, overflow
);

   // front stage: operands and the three products
   typedef struct packed {
      logic                          valid;
      mode_type                      mode;
      logic [2:0][WORD_BITS-1:0]     a;
      logic [2:0][WORD_BITS-1:0]     b;
      logic [2:0][PROD_BITS-1:0]     p;
   } front_type;

   localparam int NCELL = ROOT_BITS + QUO_BITS;

   logic                        en;
   front_type                   fr_ff, fr_in;
   item_type                    head_ff, head_in;
   item_type                    chain [NCELL+1];
   item_type                    div_head;
   item_type                    out_ff, out_in;
   logic [WORD_BITS-1:0]        fac;
   logic signed [WORD_BITS-1:0] opa, opb;
   logic [WORD_BITS:0]          sres;
   logic signed [SUM_BITS-1:0]  wide, acc;
   logic [WORD_BITS-1:0]        mag [3];

   // the chain advances as one; a bubble at the output never blocks it
   assign en         = !out_ff.valid || rsp_tready;
   assign req_tready = en;

   // stage 1: multipliers
   always_comb begin
      fr_in.valid = req_tvalid;
      fr_in.mode  = mode_type'(req_tdata[MODE_BITS-1:0]);
      fac         = req_tdata[MODE_BITS + 6*WORD_BITS +: WORD_BITS];
      for (int i = 0; i < 3; i++) begin
         fr_in.a[i] = req_tdata[MODE_BITS + i*WORD_BITS +: WORD_BITS];
         fr_in.b[i] = req_tdata[MODE_BITS + (i+3)*WORD_BITS +: WORD_BITS];
         opa = fr_in.a[i];
         case (fr_in.mode)
            MODE_SCL:  opb = fac;
            MODE_NORM: opb = fr_in.a[i];
            default:   opb = fr_in.b[i];
         endcase
         fr_in.p[i] = opa * opb;
      end
   end

   // stage 2: saturating results, dot sum, sum of squares
   always_comb begin
      head_in       = '0;
      head_in.valid = fr_ff.valid;
      acc           = '0;
      for (int i = 0; i < 3; i++) begin
         acc = acc + SUM_BITS'(signed'(fr_ff.p[i]));
      end
      for (int i = 0; i < 3; i++) begin
         case (fr_ff.mode)
            MODE_ADD: wide = SUM_BITS'(signed'(fr_ff.a[i])) + SUM_BITS'(signed'(fr_ff.b[i]));
            MODE_SUB: wide = SUM_BITS'(signed'(fr_ff.a[i])) - SUM_BITS'(signed'(fr_ff.b[i]));
            default:  wide = SUM_BITS'(signed'(fr_ff.p[i])) >>> FRAC_BITS;
         endcase
         sres = sat_word(wide);
         case (fr_ff.mode)
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_SCL: begin
               head_in.r[i] = sres[WORD_BITS-1:0];
               head_in.ovf  = head_in.ovf | sres[WORD_BITS];
            end
            MODE_NORM: head_in.r[i] = fr_ff.a[i];
            default:   head_in.r[i] = '0;
         endcase
      end
      sres = sat_word(acc >>> FRAC_BITS);
      if (fr_ff.mode == MODE_DOT) begin
         head_in.dot = sres[WORD_BITS-1:0];
         head_in.ovf = sres[WORD_BITS];
      end
      head_in.norm = (fr_ff.mode == MODE_NORM);
      head_in.rad  = acc;    // squares are non-negative
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_ff.valid   <= 1'b0;
         head_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (en) begin
         fr_ff   <= fr_in;
         head_ff <= head_in;
         out_ff  <= out_in;
      end
   end

   assign chain[0] = head_ff;

   genvar g;
   generate
      for (g = 0; g < ROOT_BITS; g++) begin : g_sqrt
         v3an_sqrt_cell u_cell (
            .clock (clock),
            .reset (reset),
            .en    (en),
            .d_in  (chain[g]),
            .d_out (chain[g+1])
         );
      end
   endgenerate

   // divider setup: remainder starts at |a|/2, last bit of |a| and zeros feed in
   always_comb begin
      div_head = chain[ROOT_BITS];
      for (int i = 0; i < 3; i++) begin
         mag[i] = chain[ROOT_BITS].r[i][WORD_BITS-1] ? (~chain[ROOT_BITS].r[i] + 1'b1)
                                                     : chain[ROOT_BITS].r[i];
         div_head.drem[i] = ROOT_BITS'(mag[i] >> 1);
         div_head.num[i]  = QUO_BITS'(mag[i][0]) << FRAC_BITS;
         div_head.q[i]    = '0;
      end
   end

   generate
      for (g = 0; g < QUO_BITS; g++) begin : g_div
         v3an_div_cell u_cell (
            .clock (clock),
            .reset (reset),
            .en    (en),
            .d_in  ((g == 0) ? div_head : chain[ROOT_BITS+g]),
            .d_out (chain[ROOT_BITS+g+1])
         );
      end
   endgenerate

   // output stage: sign the quotient back on and clamp (no flag)
   logic signed [SUM_BITS-1:0] qv;
   logic [WORD_BITS:0]         nres;

   always_comb begin
      out_in = chain[NCELL];
      for (int i = 0; i < 3; i++) begin
         qv = SUM_BITS'(chain[NCELL].q[i]);
         if (chain[NCELL].r[i][WORD_BITS-1]) begin
            qv = -qv;
         end
         nres = sat_word(qv);
         if (chain[NCELL].norm && (chain[NCELL].root != '0)) begin
            out_in.r[i] = nres[WORD_BITS-1:0];
         end
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = RSP_BITS'({out_ff.ovf, out_ff.dot, out_ff.r[2], out_ff.r[1], out_ff.r[0]});

endmodule
